>>> sv/lbp_3x3_operator_macros.svh
// Assertion macros used by the LBP 3x3 operator checker.
`ifndef LBP_3X3_OPERATOR_MACROS_SVH
`define LBP_3X3_OPERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LBP3X3_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbp3x3 check failed");

// Next-cycle implication, disabled while reset is high.
`define LBP3X3_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbp3x3 check failed");

`endif

>>> sv/lbp3x3_pkg.sv
// Package with field widths, register indexes and reset constants of the LBP 3x3 operator.
`default_nettype none

package lbp3x3_pkg;

   localparam int PIXEL_W      = 8;
   localparam int CODE_W       = 8;
   localparam int ROW_OUT_W    = 12;
   localparam int COL_OUT_W    = 10;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   localparam int MIN_DIM            = 3;
   localparam int WIDTH_RESET_VALUE  = 640;
   localparam int HEIGHT_RESET_VALUE = 480;

   // Number of pixels held in the window besides the current column.
   localparam int WINDOW_REGS = 6;

endpackage

`default_nettype wire

>>> sv/lbp3x3_if.sv
// Valid/ready channel interfaces for pixels, pattern codes and register writes.
`default_nettype none

interface lbp3x3_req_if;
   import lbp3x3_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface lbp3x3_rsp_if;
   import lbp3x3_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CODE_W-1:0]    pattern_code;
   logic [ROW_OUT_W-1:0] center_row;
   logic [COL_OUT_W-1:0] center_col;
   logic                 frame_last;

   modport source (output valid, output pattern_code, output center_row,
                   output center_col, output frame_last, input ready);
   modport sink   (input valid, input pattern_code, input center_row,
                   input center_col, input frame_last, output ready);
endinterface

interface lbp3x3_csr_if;
   import lbp3x3_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/lbp_3x3_operator.sv
// Flow: a pixel accepted into the input stage loads its pattern code into the result
// register as it leaves that stage, which it does only once the result register is free.
// Throughput: one pixel per cycle unless the result side stalls; line-buffer reads are
// issued on the accepting edge and writes happen when the item leaves the input stage, one port each.
// Border pixels produce no code. Reset clears the counters, window and valid flags and
// loads width 640 and height 480; the line buffers are not cleared.
`default_nettype none

module lbp_3x3_operator #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic         clock,
   input  logic         reset,
   lbp3x3_req_if.sink   req_chan,
   lbp3x3_rsp_if.source rsp_chan,
   lbp3x3_csr_if.sink   csr_chan
);
   import lbp3x3_pkg::*;

   // Column and row counters only need to reach the largest legal image size.
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET =
      (MAX_WIDTH < WIDTH_RESET_VALUE) ? WIDTH_REG_W'(MAX_WIDTH) : WIDTH_REG_W'(WIDTH_RESET_VALUE);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET =
      (MAX_HEIGHT < HEIGHT_RESET_VALUE) ? HEIGHT_REG_W'(MAX_HEIGHT)
                                        : HEIGHT_REG_W'(HEIGHT_RESET_VALUE);

   // Written sizes are saturated into the legal range.
   function automatic logic [WIDTH_REG_W-1:0] clamp_width(input logic [WIDTH_REG_W-1:0] v);
      if (int'(v) < MIN_DIM) begin
         return WIDTH_REG_W'(MIN_DIM);
      end
      if (int'(v) > MAX_WIDTH) begin
         return WIDTH_REG_W'(MAX_WIDTH);
      end
      return v;
   endfunction

   function automatic logic [HEIGHT_REG_W-1:0] clamp_height(input logic [HEIGHT_REG_W-1:0] v);
      if (int'(v) < MIN_DIM) begin
         return HEIGHT_REG_W'(MIN_DIM);
      end
      if (int'(v) > MAX_HEIGHT) begin
         return HEIGHT_REG_W'(MAX_HEIGHT);
      end
      return v;
   endfunction

   // Configuration registers.
   logic [WIDTH_REG_W-1:0]  image_width_ff, image_width_in;
   logic [HEIGHT_REG_W-1:0] image_height_ff, image_height_in;

   // Position of the next pixel to arrive.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W:0]   col_inc;
   logic [ROW_W:0]   row_inc;
   logic             col_wrap;
   logic             row_wrap;

   // Input stage: the accepted pixel, its position and the two line-buffer words above it.
   logic               a_valid_ff, a_valid_in;
   logic [PIXEL_W-1:0] a_pixel_ff;
   logic [PIXEL_W-1:0] a_top_ff;
   logic [PIXEL_W-1:0] a_mid_ff;
   logic [COL_W-1:0]   a_col_ff;
   logic [ROW_W-1:0]   a_row_ff;

   // Line buffers: line_a holds the previous row, line_b the row before that.
   logic [PIXEL_W-1:0] line_a_mem [MAX_WIDTH];
   logic [PIXEL_W-1:0] line_b_mem [MAX_WIDTH];

   // Window columns c-1 (entries 0..2) and c-2 (entries 3..5), top to bottom.
   logic [PIXEL_W-1:0] window_ff [WINDOW_REGS];
   logic [PIXEL_W-1:0] window_in [WINDOW_REGS];

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]    code_ff;
   logic [ROW_OUT_W-1:0] center_row_ff;
   logic [COL_OUT_W-1:0] center_col_ff;
   logic                 frame_last_ff;

   logic               req_accept;
   logic               csr_accept;
   logic               a_emit;
   logic               a_advance;
   logic [PIXEL_W-1:0] centre;
   logic [CODE_W-1:0]  code;
   logic [ROW_W-1:0]   row_m1;
   logic [COL_W-1:0]   col_m1;
   logic               frame_last;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign csr_accept = csr_chan.valid && csr_chan.ready;

   // Register writes are always taken at once.
   assign csr_chan.ready = 1'b1;

   // A window is complete once two rows and two columns have gone by. An item
   // that produces no code leaves the input stage regardless of the result side.
   assign a_emit    = (int'(a_row_ff) >= 2) && (int'(a_col_ff) >= 2);
   assign a_advance = a_valid_ff && (!a_emit || !rsp_valid_ff || rsp_chan.ready);

   // The input stage takes a new pixel when it is empty or its current one moves on in the same cycle.
   assign req_chan.ready = !a_valid_ff || a_advance;

   // Neighbour compares against the centre, clockwise from up.
   assign centre = window_ff[1];
   always_comb begin
      code    = '0;
      code[0] = window_ff[0] > centre;
      code[1] = a_top_ff     > centre;
      code[2] = a_mid_ff     > centre;
      code[3] = a_pixel_ff   > centre;
      code[4] = window_ff[2] > centre;
      code[5] = window_ff[5] > centre;
      code[6] = window_ff[4] > centre;
      code[7] = window_ff[3] > centre;
   end

   assign row_m1     = a_row_ff - ROW_W'(1);
   assign col_m1     = a_col_ff - COL_W'(1);
   assign frame_last = (32'(a_row_ff) + 32'd1 == 32'(image_height_ff))
                    && (32'(a_col_ff) + 32'd1 == 32'(image_width_ff));

   // Raster position of the next pixel; a full frame wraps to the origin.
   assign col_inc  = {1'b0, col_ff} + (COL_W + 1)'(1);
   assign row_inc  = {1'b0, row_ff} + (ROW_W + 1)'(1);
   assign col_wrap = 32'(col_inc) >= 32'(image_width_ff);
   assign row_wrap = 32'(row_inc) >= 32'(image_height_ff);

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      if (req_accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end
      // A decoded register write restarts the frame; user must write only while idle (not enforced).
      if (csr_accept) begin
         case (csr_chan.index)
            CSR_IMAGE_WIDTH: begin
               image_width_in = clamp_width(csr_chan.data[WIDTH_REG_W-1:0]);
               col_in         = '0;
               row_in         = '0;
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_in = clamp_height(csr_chan.data[HEIGHT_REG_W-1:0]);
               col_in          = '0;
               row_in          = '0;
            end
            default: begin
               image_width_in = image_width_ff;
            end
         endcase
      end
   end

   // The window shifts by one column each time an item leaves the input stage.
   always_comb begin
      for (int i = 0; i < WINDOW_REGS; i++) begin
         window_in[i] = window_ff[i];
      end
      if (a_advance) begin
         window_in[3] = window_ff[0];
         window_in[4] = window_ff[1];
         window_in[5] = window_ff[2];
         window_in[0] = a_top_ff;
         window_in[1] = a_mid_ff;
         window_in[2] = a_pixel_ff;
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_accept) begin
         a_valid_in = 1'b1;
      end else if (a_advance) begin
         a_valid_in = 1'b0;
      end
   end

   // The result register holds its code until the downstream side takes the transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (a_advance && a_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         a_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < WINDOW_REGS; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         a_valid_ff      <= a_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         for (int i = 0; i < WINDOW_REGS; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   // Line-buffer reads for the arriving pixel and writes for the departing one.
   // Both addresses differ in any cycle, since a row has at least three columns.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_top_ff   <= line_b_mem[col_ff];
         a_mid_ff   <= line_a_mem[col_ff];
         a_pixel_ff <= req_chan.pixel;
         a_col_ff   <= col_ff;
         a_row_ff   <= row_ff;
      end
      if (a_advance) begin
         line_b_mem[a_col_ff] <= a_mid_ff;
         line_a_mem[a_col_ff] <= a_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_advance && a_emit) begin
         code_ff       <= code;
         center_row_ff <= ROW_OUT_W'(row_m1);
         center_col_ff <= COL_OUT_W'(col_m1);
         frame_last_ff <= frame_last;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pattern_code = code_ff;
   assign rsp_chan.center_row   = center_row_ff;
   assign rsp_chan.center_col   = center_col_ff;
   assign rsp_chan.frame_last   = frame_last_ff;

endmodule

`default_nettype wire

>>> sv/lbp3x3_checker.sv
// Port-level checks for the LBP 3x3 operator and the bind that attaches them.
`default_nettype none

`include "lbp_3x3_operator_macros.svh"

module lbp3x3_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [lbp3x3_pkg::ROW_OUT_W-1:0] rsp_center_row,
   input logic [lbp3x3_pkg::COL_OUT_W-1:0] rsp_center_col
);
   import lbp3x3_pkg::*;

   // A pending code is not withdrawn before it is taken.
   `LBP3X3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Codes are only formed for interior centres.
   `LBP3X3_ASSERT_IMP(a_interior, clock, reset, rsp_valid,
      rsp_center_row != '0 && rsp_center_col != '0)

   // A code that newly appears comes from an earlier pixel transfer: when the result register
   // is empty, the pixel moves from the input stage register straight into it.
   `LBP3X3_ASSERT_IMP(a_rsp_cause, clock, reset, $rose(rsp_valid),
      $past(req_valid && req_ready, 2))

endmodule

bind lbp_3x3_operator lbp3x3_checker u_lbp3x3_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_center_row (rsp_chan.center_row),
   .rsp_center_col (rsp_chan.center_col)
);

`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the 3x3 local binary pattern operator, driven through its channels.
`timescale 1ns / 100ps

module tb;
   import lbp3x3_pkg::*;

   // Defaults of the block's size parameters; the scoreboard model uses the same limits.
   localparam int unsigned MAX_W = 1024;
   localparam int unsigned MAX_H = 4096;

   // A code can transfer only once its pixel has gone through the input stage into the result
   // register, so the settle cycles cover any pixel still in flight after the last code is in.
   localparam int SETTLE_CYCLES    = 4;
   localparam int END_CYCLES       = 8;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int WATCHDOG_LIMIT   = 1000;
   localparam int RANDOM_ITEMS     = 540;
   localparam int TALL_ROWS        = 12;
   localparam int MAX_REPORTS      = 100;

   // Register index that the block does not decode; a write there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = CSR_INDEX_W'(7);
   localparam logic [CSR_INDEX_W-1:0] NO_INDEX        = '0;

   typedef struct packed {
      logic [CODE_W-1:0]    code;
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
      logic                 last;
   } lbp_result_type;

   // Travels with each offered pixel: a typed row carries its code in the table.
   typedef struct packed {
      bit             typed;
      lbp_result_type want;
   } code_tag_type;

   typedef enum logic {STEP_PIXEL, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type          kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
      bit                     typed;
      lbp_result_type         want;
   } directed_step_type;

   localparam lbp_result_type NO_CODE = '0;
   localparam int DIRECTED_ROWS = 28;

   // Directed table. The first frame is 3x3 with a black centre among white neighbours,
   // so every neighbour is greater and the code is all ones. A write to an unused index
   // lands in the middle of that frame and must not restart it. Then a partial row is
   // cut short by a width write whose upper data bits must be masked off (width 4), and
   // a flat 4x3 frame follows, where equal neighbours give all-zero codes.
   directed_step_type directed_steps [DIRECTED_ROWS] = '{
      '{STEP_CSR,   CSR_IMAGE_WIDTH,  16'h0000, 1'b0, NO_CODE},  // saturates up to 3
      '{STEP_CSR,   CSR_IMAGE_HEIGHT, 16'h0002, 1'b0, NO_CODE},  // saturates up to 3
      '{STEP_PIXEL, NO_INDEX,         16'd255,  1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'd255,  1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'd255,  1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'd255,  1'b0, NO_CODE},
      '{STEP_CSR,   CSR_SPARE_INDEX,  16'hFFFF, 1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'd0,    1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'd255,  1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'd255,  1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'd255,  1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'd255,  1'b1, '{8'hFF, 12'd1, 10'd1, 1'b1}},
      '{STEP_PIXEL, NO_INDEX,         16'd10,   1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'd20,   1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'd30,   1'b0, NO_CODE},
      '{STEP_CSR,   CSR_IMAGE_WIDTH,  16'hF804, 1'b0, NO_CODE},  // masked down to 4
      '{STEP_PIXEL, NO_INDEX,         16'h40,   1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'h40,   1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'h40,   1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'h40,   1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'h40,   1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'h40,   1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'h40,   1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'h40,   1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'h40,   1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'h40,   1'b0, NO_CODE},
      '{STEP_PIXEL, NO_INDEX,         16'h40,   1'b1, '{8'h00, 12'd1, 10'd1, 1'b0}},
      '{STEP_PIXEL, NO_INDEX,         16'h40,   1'b1, '{8'h00, 12'd1, 10'd2, 1'b1}}
   };

   logic clock;
   logic reset;

   lbp3x3_req_if req_if ();
   lbp3x3_rsp_if rsp_if ();
   lbp3x3_csr_if csr_if ();

   lbp_3x3_operator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Scoreboard model of the operator: two previous rows, the two previous window
   // columns (top, middle, bottom), the position of the next pixel and the frame size.
   logic [PIXEL_W-1:0] row_older [MAX_W] = '{default: '0};
   logic [PIXEL_W-1:0] row_newer [MAX_W] = '{default: '0};
   logic [PIXEL_W-1:0] up_c1, mid_c1, low_c1, up_c2, mid_c2, low_c2;
   int unsigned row_at, col_at;
   int unsigned frame_w = WIDTH_RESET_VALUE;
   int unsigned frame_h = HEIGHT_RESET_VALUE;

   lbp_result_type pending_codes [$];
   code_tag_type   offered_tags [$];

   bit idle_on;
   bit long_hold_req;
   int fail_count;
   int quiet_cycles;
   int pixels_in, codes_out, frame_ends, csr_writes;

   initial begin
      {up_c1, mid_c1, low_c1, up_c2, mid_c2, low_c2} = '0;
      row_at = 0;
      col_at = 0;
   end

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   // Any decoded register write restarts the frame; the row stores keep their contents,
   // but rows 0 and 1 of the new frame rewrite them before anything reads them.
   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_IMAGE_WIDTH)
         frame_w = clamp_dim(data[WIDTH_REG_W-1:0], MAX_W);
      else if (idx == CSR_IMAGE_HEIGHT)
         frame_h = clamp_dim(data[HEIGHT_REG_W-1:0], MAX_H);
      else
         return;
      row_at = 0;
      col_at = 0;
   endfunction

   // Pushes one pixel through the window. When the pixel at (r, c) arrives with r and c
   // both at least 2, the window around (r-1, c-1) is complete and a code is formed:
   // each bit says that neighbour is strictly brighter than the centre, bit 0 being the
   // one above and the rest following clockwise.
   function automatic bit step_lbp_window(input logic [PIXEL_W-1:0] px,
                                          output lbp_result_type res);
      logic [PIXEL_W-1:0] above, beside, ctr;
      bit emit;
      above  = row_older[col_at];
      beside = row_newer[col_at];
      ctr    = mid_c1;
      emit   = (row_at >= 2) && (col_at >= 2);
      res.code = {up_c2 > ctr, mid_c2 > ctr, low_c2 > ctr, low_c1 > ctr,
                  px > ctr, beside > ctr, above > ctr, up_c1 > ctr};
      res.row  = ROW_OUT_W'(row_at - 1);
      res.col  = COL_OUT_W'(col_at - 1);
      res.last = (row_at + 1 == frame_h) && (col_at + 1 == frame_w);

      up_c2  = up_c1;
      mid_c2 = mid_c1;
      low_c2 = low_c1;
      up_c1  = above;
      mid_c1 = beside;
      low_c1 = px;
      row_older[col_at] = beside;
      row_newer[col_at] = px;

      // The counters wrap to the top left corner after the last pixel of a frame.
      col_at++;
      if (col_at >= frame_w) begin
         col_at = 0;
         row_at++;
         if (row_at >= frame_h) row_at = 0;
      end
      return emit;
   endfunction

   function automatic void report_field(input string name, input int want, input int got);
      if (fail_count < MAX_REPORTS)
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
   endfunction

   function automatic void compare_code(input lbp_result_type want,
                                        input lbp_result_type got);
      if (got.code !== want.code) report_field("pattern_code", want.code, got.code);
      if (got.row !== want.row) report_field("center_row", want.row, got.row);
      if (got.col !== want.col) report_field("center_col", want.col, got.col);
      if (got.last !== want.last) report_field("frame_last", want.last, got.last);
   endfunction

   // Everything is sampled on the rising edge, where the values set up at the falling
   // edge are stable. Codes are checked before the pixel of the same edge is modeled,
   // so the order of the two queues never depends on process scheduling.
   always @(posedge clock) begin : scoreboard
      lbp_result_type seen, want, calc;
      code_tag_type tag;
      bit moved, emits;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            codes_out++;
            seen = '{rsp_if.pattern_code, rsp_if.center_row, rsp_if.center_col,
                     rsp_if.frame_last};
            if (seen.last === 1'b1) frame_ends++;
            if (pending_codes.size() == 0) begin
               if (fail_count < MAX_REPORTS)
                  $error("unexpected pattern code %02h for row %0d, column %0d",
                         seen.code, seen.row, seen.col);
               fail_count++;
            end else begin
               want = pending_codes.pop_front();
               compare_code(want, seen);
            end
         end
         if (req_if.valid && req_if.ready) begin
            moved = 1'b1;
            pixels_in++;
            tag = '0;
            if (offered_tags.size() != 0) tag = offered_tags.pop_front();
            emits = step_lbp_window(req_if.pixel, calc);
            if (tag.typed)
               pending_codes.push_back(tag.want);
            else if (emits)
               pending_codes.push_back(calc);
         end
         if (csr_if.valid && csr_if.ready) begin
            moved = 1'b1;
            csr_writes++;
            apply_register(csr_if.index, csr_if.data);
         end
         // A run that stops moving is a hang: give up after a long quiet stretch.
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles, %0d codes still awaited",
                   quiet_cycles, pending_codes.size());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Code receiver. While idle_on is set it draws a stall before each transfer and, when asked,
   // holds ready low for a long stretch counted here, so that the block backs up into its input.
   initial begin : code_receiver
      int unsigned stall;
      rsp_if.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 17) : 0;
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall = LONG_HOLD_CYCLES;
         end
         if (stall != 0) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
      end
   end

   // Offers one pixel after a drawn gap and returns at the edge of its transfer. Valid
   // stays high into the next offer when no gap is drawn, so it is assigned once a step.
   task automatic offer_pixel(input logic [PIXEL_W-1:0] px, input code_tag_type tag);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 17) : 0;
      offered_tags.push_back(tag);
      if (gap != 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.pixel <= px;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_codes.size() != 0) @(negedge clock);
   endtask

   // Registers change only with the block idle: every awaited code has arrived and any
   // border pixel still in the pipeline has had time to leave it.
   task automatic configure(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Random pixels cluster around a drifting level so that equal and nearly equal
   // neighbours are common; a quarter of them span the whole range.
   task automatic send_random_pixels(input int unsigned count, input int pause_at);
      int unsigned level;
      logic [PIXEL_W-1:0] px;
      level = $urandom_range(0, 255);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) hold_until_drained();
         if ($urandom_range(0, 31) == 0) level = $urandom_range(0, 255);
         if ($urandom_range(0, 3) == 0)
            px = PIXEL_W'($urandom_range(0, 255));
         else
            px = PIXEL_W'(level + $urandom_range(0, 3));
         offer_pixel(px, '0);
      end
   endtask

   initial begin : stimulus
      code_tag_type tag;
      int unsigned w, h, count, random_items;
      int pause_at;
      logic [CSR_DATA_W-1:0] width_word, height_word, junk_word;
      logic [CSR_INDEX_W-1:0] junk_index;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.pixel = '0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data  = '0;
      idle_on = 1'b1;
      long_hold_req = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: walk the table; typed rows are compared with their typed code.
      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR) begin
            configure(directed_steps[i].index, directed_steps[i].value);
         end else begin
            tag.typed = directed_steps[i].typed;
            tag.want  = directed_steps[i].want;
            offer_pixel(directed_steps[i].value[PIXEL_W-1:0], tag);
         end
      end

      // Back-pressure: the sender streams without gaps while the receiver sits on a
      // long stall after its first code, so the pipeline fills and input ready drops.
      // Halfway through, the sender stops until every awaited code is in.
      configure(CSR_IMAGE_WIDTH, CSR_DATA_W'(5));
      configure(CSR_IMAGE_HEIGHT, CSR_DATA_W'(30));
      idle_on = 1'b0;
      long_hold_req = 1'b1;
      send_random_pixels(frame_w * frame_h, (frame_w * frame_h) / 2);

      // Random frames of small sizes. Upper data bits beyond each register are random
      // and must be ignored; now and then a size below the minimum must saturate, a
      // write to an undecoded index is mixed in, and frames are left half finished.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         w = $urandom_range(MIN_DIM, 12);
         if ($urandom_range(0, 7) == 0) w = $urandom_range(13, 24);
         h = $urandom_range(MIN_DIM, 8);
         width_word = CSR_DATA_W'($urandom);
         width_word[WIDTH_REG_W-1:0] = WIDTH_REG_W'(w);
         if ($urandom_range(0, 9) == 0) width_word = CSR_DATA_W'($urandom_range(0, 2));
         height_word = CSR_DATA_W'($urandom);
         height_word[HEIGHT_REG_W-1:0] = HEIGHT_REG_W'(h);
         if ($urandom_range(0, 9) == 0) height_word = CSR_DATA_W'($urandom_range(0, 2));

         case ($urandom_range(0, 3))
            0: configure(CSR_IMAGE_HEIGHT, height_word);
            1: configure(CSR_IMAGE_WIDTH, width_word);
            default: begin
               configure(CSR_IMAGE_WIDTH, width_word);
               configure(CSR_IMAGE_HEIGHT, height_word);
            end
         endcase
         if ($urandom_range(0, 3) == 0) begin
            junk_index = CSR_INDEX_W'($urandom_range(CSR_IMAGE_HEIGHT + 1,
                                                     (1 << CSR_INDEX_W) - 1));
            junk_word = CSR_DATA_W'($urandom);
            configure(junk_index, junk_word);
         end

         idle_on = ($urandom_range(0, 3) != 0);
         count = frame_w * frame_h * $urandom_range(1, 2)
               + $urandom_range(0, frame_w * frame_h - 1);
         pause_at = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, count - 1)) : -1;
         send_random_pixels(count, pause_at);
         random_items += count;
      end

      // A tall narrow frame, streamed without gaps. The height write carries a value
      // above the maximum, which saturates, so none of these codes closes the frame.
      idle_on = 1'b0;
      configure(CSR_IMAGE_WIDTH, CSR_DATA_W'(MIN_DIM));
      configure(CSR_IMAGE_HEIGHT, CSR_DATA_W'(16'hFFFF));
      send_random_pixels(TALL_ROWS * frame_w, -1);

      hold_until_drained();
      repeat (END_CYCLES) @(negedge clock);

      $display("Run covered %0d pixel transfers, %0d pattern codes over %0d frame ends,",
               pixels_in, codes_out, frame_ends);
      $display("and %0d register writes, on frames from 3x3 to 24 columns and one of 4096 rows.",
               csr_writes);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/lbp3x3_pkg.sv
sv/lbp3x3_if.sv
sv/lbp_3x3_operator.sv
sv/lbp3x3_checker.sv
bench/tb.sv
